/* rtl/pa_ik_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pa_ik_pkg
// Constants, register codes and helper functions of the planar arm IK core.
// ----------------------------------------------------------------------------
package pa_ik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;

  // angles, sines and cosines in units of 2^-30, PI_Q13 in units of 2^-13
  localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [47:0] GAIN_INV_Q30 = 48'sd652032874;
  localparam logic signed [20:0] PI_Q13       = 21'sd25736;

  // register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_FORE  = 2'd2;
  localparam logic [1:0] REG_TOOL  = 2'd3;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  // product in 2^-30 units rounded half up to integer
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p + 66'sd536870912;
    return s[65:30];
  endfunction

endpackage

/* rtl/planar_arm_inverse_kinematics_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_arm_inverse_kinematics_core
// Three-joint planar arm IK: law of cosines elbow, CORDIC atan2 shoulder.
// ----------------------------------------------------------------------------
// One request at a time: a pose is taken when in_tready is high, and the
// time until the answer appears on the output register depends on how far
// the two atan2 operand pairs must be normalised. An unreachable target is
// answered from the reach check ahead of the divider, or from the check
// behind the square root when the elbow folds back onto the shoulder. An
// answer still waiting on out_tready holds the sequencer in its last state
// until the output register is free. The core is one sequencer driving a
// shared CORDIC stage (CORDIC_STEPS passes for sin/cos and for each of two
// atan2), a one bit per cycle divider (31 steps), a one bit per cycle square
// root (31 steps) and a single 33x33 multiplier used for fourteen products.
// The next request is taken as soon as the answer is in the output register.
module planar_arm_inverse_kinematics_core #(
  parameter int CORDIC_STEPS = pa_ik_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // target_x[23:0], target_y[47:24], target_angle[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // shoulder[15:0], elbow[31:16], wrist[47:32]
  output logic [3:0]  out_tuser,   // kept_mask[2:0], unreachable[3]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pa_ik_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SC_INIT, S_SC_RUN, S_MA, S_MB, S_MC, S_MD, S_ME, S_MF, S_MG, S_MH,
    S_CHK, S_DIV, S_QSQ, S_SQ_INIT, S_SQ, S_N1, S_N2, S_N3, S_N4,
    S_P1, S_P2, S_P3, S_P4, S_AT_NORM, S_AT_RUN, S_AT_DONE, S_UPD, S_FIN
  } state_t;

  localparam logic signed [47:0] LIM40  = 48'sh010000000000;
  localparam logic signed [47:0] LIM36  = 48'sh001000000000;
  localparam logic signed [47:0] NLIM40 = -LIM40;
  localparam logic signed [47:0] NLIM36 = -LIM36;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] LAST_BIT  = 5'd30;

  state_t state_r;
  logic [4:0] cnt_r;
  logic signed [23:0] px_r, py_r;
  logic signed [15:0] alpha_r;
  logic signed [47:0] cx_r, cy_r, sx_r, sy_r;
  logic signed [35:0] cz_r;
  logic flip_r, neg_r, which_r;
  logic signed [65:0] prod_r;
  logic signed [25:0] a_r;
  logic signed [26:0] b_r;
  logic signed [55:0] acc_r;
  logic [33:0] den_r, rem_r;
  logic [55:0] absn_r;
  logic [30:0] dq_r, q_r;
  logic [60:0] sv_r, sbit_r;
  logic [61:0] sr_r;
  logic signed [31:0] c1_r, s1_r;
  logic signed [18:0] m_r, n_r, f0_r, f1_r;
  logic [15:0] sh_r, el_r, wr_r;
  logic [2:0] kept_r;
  logic unr_r;
  logic out_valid_r;
  logic [47:0] out_data_r;
  logic [3:0] out_user_r;
  logic [15:0] base_r, upper_r, fore_r, tool_r;

  // shared CORDIC stage
  logic signed [47:0] dx, dy, cx_nxt, cy_nxt;
  logic signed [35:0] cz_nxt, at;
  logic pos, last_step;

  always_comb begin
    dx = cy_r >>> cnt_r;
    dy = cx_r >>> cnt_r;
    at = $signed({6'b0, atan_q30(cnt_r)});
    pos = (state_r == S_SC_RUN) ? !cz_r[35] : cy_r[47];
    if (pos) begin
      cx_nxt = cx_r - dx;
      cy_nxt = cy_r + dy;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + dx;
      cy_nxt = cy_r - dy;
      cz_nxt = cz_r + at;
    end
    last_step = (cnt_r == LAST_STEP);
  end

  // shared multiplier operands
  logic signed [32:0] ma, mb, l1_op, l2_op, tl_op;
  logic signed [47:0] sin_v, cos_v;

  always_comb begin
    l1_op = $signed({17'b0, upper_r});
    l2_op = $signed({17'b0, fore_r});
    tl_op = $signed({17'b0, tool_r});
    sin_v = flip_r ? -cy_r : cy_r;
    cos_v = flip_r ? -cx_r : cx_r;
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_MA:    begin ma = sin_v[32:0]; mb = tl_op; end
      S_MB:    begin ma = cos_v[32:0]; mb = tl_op; end
      S_MC:    begin ma = l1_op; mb = l1_op; end
      S_MD:    begin ma = l2_op; mb = l2_op; end
      S_ME:    begin ma = 33'(a_r); mb = 33'(a_r); end
      S_MF:    begin ma = 33'(b_r); mb = 33'(b_r); end
      S_MG:    begin ma = l1_op; mb = l2_op; end
      S_QSQ:   begin ma = $signed({2'b0, q_r}); mb = $signed({2'b0, q_r}); end
      S_N2:    begin ma = 33'(c1_r); mb = l2_op; end
      S_N3:    begin ma = 33'(s1_r); mb = l2_op; end
      S_N4:    begin ma = 33'(m_r); mb = 33'(a_r); end
      S_P1:    begin ma = 33'(n_r); mb = 33'(b_r); end
      S_P2:    begin ma = 33'(n_r); mb = 33'(a_r); end
      S_P3:    begin ma = 33'(m_r); mb = 33'(b_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // misc datapath
  logic signed [35:0] r30, z0, a_new, b_new, m_new, zr;
  logic signed [18:0] f_new;
  logic [64:0] dvd;
  logic [34:0] dt, ddiff;
  logic dge;
  logic [61:0] trial;
  logic sge;
  logic small36, small40;
  logic signed [20:0] f0e, f1e, w_new;
  logic ok0, ok1, ok2;

  always_comb begin
    r30   = rnd30(prod_r);
    z0    = $signed({{3{alpha_r[15]}}, alpha_r, 17'b0});
    a_new = -36'(px_r) - r30;
    b_new = 36'(py_r) - $signed({20'b0, base_r}) - r30;
    m_new = $signed({20'b0, upper_r}) + r30;
    dvd   = {absn_r[34:0], 30'b0} + {32'b0, den_r[33:1]};
    dt    = {rem_r, dq_r[30]};
    dge   = dt >= {1'b0, den_r};
    ddiff = dt - {1'b0, den_r};
    trial = sr_r + {1'b0, sbit_r};
    sge   = {1'b0, sv_r} >= trial;
    small40 = (cx_r < LIM40) && (cx_r > NLIM40) && (cy_r < LIM40) && (cy_r > NLIM40);
    small36 = (cx_r < LIM36) && (cx_r > NLIM36) && (cy_r < LIM36) && (cy_r > NLIM36);
    zr    = cz_r + 36'sd65536;
    f_new = zr[35:17];
    f0e   = 21'(f0_r);
    f1e   = 21'(f1_r);
    w_new = 21'(alpha_r) + f0e - f1e;
    ok0   = (f0e >= -PI_Q13) && (f0e <= PI_Q13);
    ok1   = (f1e >= -PI_Q13) && (f1e <= PI_Q13);
    ok2   = (w_new >= -PI_Q13) && (w_new <= PI_Q13);
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sh_r        <= '0;
      el_r        <= '0;
      wr_r        <= '0;
      kept_r      <= '0;
      unr_r       <= 1'b0;
      out_valid_r <= 1'b0;
      which_r     <= 1'b0;
      flip_r      <= 1'b0;
    end else begin
      // the output load below takes over in the final state
      if (out_valid_r && out_tready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r    <= $signed(in_tdata[23:0]);
            py_r    <= $signed(in_tdata[47:24]);
            alpha_r <= $signed(in_tdata[63:48]);
            state_r <= S_SC_INIT;
          end
        end
        S_SC_INIT: begin
          // fold into +-pi/2, negate the result afterwards
          if (z0 > HALF_PI_Q30) begin
            cz_r <= z0 - PI_Q30; flip_r <= 1'b1;
          end else if (z0 < -HALF_PI_Q30) begin
            cz_r <= z0 + PI_Q30; flip_r <= 1'b1;
          end else begin
            cz_r <= z0; flip_r <= 1'b0;
          end
          cx_r    <= GAIN_INV_Q30;
          cy_r    <= '0;
          cnt_r   <= '0;
          state_r <= S_SC_RUN;
        end
        S_SC_RUN: begin
          cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (last_step) state_r <= S_MA;
        end
        S_MA: state_r <= S_MB;
        S_MB: begin a_r <= a_new[25:0]; state_r <= S_MC; end
        S_MC: begin b_r <= b_new[26:0]; state_r <= S_MD; end
        S_MD: begin acc_r <= -56'(prod_r); state_r <= S_ME; end
        S_ME: begin acc_r <= acc_r - 56'(prod_r); state_r <= S_MF; end
        S_MF: begin acc_r <= acc_r + 56'(prod_r); state_r <= S_MG; end
        S_MG: begin acc_r <= acc_r + 56'(prod_r); state_r <= S_MH; end
        S_MH: begin
          den_r   <= {prod_r[32:0], 1'b0};
          absn_r  <= acc_r[55] ? 56'(-acc_r) : 56'(acc_r);
          neg_r   <= acc_r[55];
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (den_r == '0 || absn_r > 56'(den_r)) begin
            kept_r <= 3'b111; unr_r <= 1'b1; state_r <= S_FIN;
          end else begin
            rem_r   <= dvd[64:31];
            dq_r    <= dvd[30:0];
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= dge ? ddiff[33:0] : dt[33:0];
          q_r   <= {q_r[29:0], dge};
          dq_r  <= {dq_r[29:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == LAST_BIT) state_r <= S_QSQ;
        end
        S_QSQ: state_r <= S_SQ_INIT;
        S_SQ_INIT: begin
          sv_r    <= {1'b1, 60'b0} - prod_r[60:0];
          sr_r    <= '0;
          sbit_r  <= {1'b1, 60'b0};
          cnt_r   <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (sge) begin
            sv_r <= sv_r - trial[60:0];
            sr_r <= (sr_r >> 1) + {1'b0, sbit_r};
          end else begin
            sr_r <= sr_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == LAST_BIT) state_r <= S_N1;
        end
        S_N1: begin
          c1_r    <= neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
          s1_r    <= -$signed({1'b0, sr_r[30:0]});
          state_r <= S_N2;
        end
        S_N2: state_r <= S_N3;
        S_N3: begin m_r <= m_new[18:0]; state_r <= S_N4; end
        S_N4: begin
          n_r <= r30[18:0];
          if (m_r == '0 && r30[18:0] == '0) begin
            kept_r <= 3'b111; unr_r <= 1'b1; state_r <= S_FIN;
          end else begin
            state_r <= S_P1;
          end
        end
        S_P1: begin acc_r <= -56'(prod_r); state_r <= S_P2; end
        S_P2: begin acc_r <= acc_r + 56'(prod_r); state_r <= S_P3; end
        S_P3: begin
          sy_r    <= acc_r[47:0];
          acc_r   <= 56'(prod_r);
          state_r <= S_P4;
        end
        S_P4: begin
          sx_r    <= 48'(acc_r + 56'(prod_r));
          cx_r    <= 48'(c1_r);
          cy_r    <= 48'(s1_r);
          cz_r    <= '0;
          which_r <= 1'b0;
          state_r <= S_AT_NORM;
        end
        S_AT_NORM: begin
          if (cx_r == '0 && cy_r == '0) begin
            cz_r <= '0; state_r <= S_AT_DONE;
          end else if (small36) begin
            cx_r <= cx_r <<< 4; cy_r <= cy_r <<< 4;
          end else if (small40) begin
            cx_r <= cx_r <<< 1; cy_r <= cy_r <<< 1;
          end else begin
            // quarter-turn pre-rotation for the left half plane
            if (cx_r[47]) begin
              if (cy_r > 48'sd0) begin
                cx_r <= cy_r; cy_r <= -cx_r; cz_r <= HALF_PI_Q30;
              end else begin
                cx_r <= -cy_r; cy_r <= cx_r; cz_r <= -HALF_PI_Q30;
              end
            end else begin
              cz_r <= '0;
            end
            cnt_r   <= '0;
            state_r <= S_AT_RUN;
          end
        end
        S_AT_RUN: begin
          cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (last_step) state_r <= S_AT_DONE;
        end
        S_AT_DONE: begin
          if (!which_r) begin
            f1_r    <= f_new;
            cx_r    <= sx_r;
            cy_r    <= sy_r;
            cz_r    <= '0;
            which_r <= 1'b1;
            state_r <= S_AT_NORM;
          end else begin
            f0_r    <= f_new;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (ok0) sh_r <= f0_r[15:0];
          if (ok1) el_r <= f1_r[15:0];
          if (ok2) wr_r <= w_new[15:0];
          kept_r  <= {!ok2, !ok1, !ok0};
          unr_r   <= 1'b0;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {wr_r, el_r, sh_r};
            out_user_r  <= {unr_r, kept_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // configuration registers
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 16'd0;
      upper_r <= 16'd25600;
      fore_r  <= 16'd25600;
      tool_r  <= 16'd12800;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_BASE:  base_r  <= cfg_pwdata[15:0];
        REG_UPPER: upper_r <= cfg_pwdata[15:0];
        REG_FORE:  fore_r  <= cfg_pwdata[15:0];
        REG_TOOL:  tool_r  <= cfg_pwdata[15:0];
        default:   base_r  <= base_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_BASE:  cfg_prdata = {16'b0, base_r};
      REG_UPPER: cfg_prdata = {16'b0, upper_r};
      REG_FORE:  cfg_prdata = {16'b0, fore_r};
      REG_TOOL:  cfg_prdata = {16'b0, tool_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer took a request while busy");

  a_unreach_all_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == 3'b111)
    else $error("unreachable answer without full kept mask");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) >= -16'sd25736)
                && ($signed(out_tdata[15:0]) <= 16'sd25736)
                && ($signed(out_tdata[31:16]) >= -16'sd25736)
                && ($signed(out_tdata[31:16]) <= 16'sd25736)
                && ($signed(out_tdata[47:32]) >= -16'sd25736)
                && ($signed(out_tdata[47:32]) <= 16'sd25736))
    else $error("stored joint angle beyond pi");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd31)
    else $error("step counter out of range");
`endif

endmodule
